FILE: hw/rtl/sduck_pkg.sv
// ---------------------------------------------------------------------------
// sduck_pkg
// shared types and constants of the sidechain ducking envelope
// ---------------------------------------------------------------------------
package sduck_pkg;

   localparam int GAIN_W  = 16;
   localparam int STAMP_W = 16;
   localparam int AGE_W   = 18;
   localparam int ATK_W   = 12;
   localparam int PROD_W  = 32;

   localparam logic [GAIN_W-1:0] UNITY   = 16'h8000;
   localparam logic [AGE_W-1:0]  AGE_MAX = 18'h3ffff;

   // divider: quotient bits retired per clock
   localparam int DIV_BITS   = 4;
   localparam int DIV_PASSES = GAIN_W / DIV_BITS;
   localparam int DIV_CNT_W  = $clog2(DIV_PASSES);

   // register indexes of the configuration port
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTACK_LEN  = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLD_LEN    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_RELEASE_LEN = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_MIN_GAIN    = 8'd3;

   localparam logic [ATK_W-1:0]  ATTACK_LEN_RST  = 12'd96;
   localparam logic [15:0]       HOLD_LEN_RST    = 16'd480;
   localparam logic [15:0]       RELEASE_LEN_RST = 16'd7200;
   localparam logic [GAIN_W-1:0] MIN_GAIN_RST    = 16'd14636;

   typedef struct packed {
      logic push;
      logic pop;
   } fifo_ctrl_type;

endpackage

FILE: hw/rtl/sidechain_duck_envelope_top.sv
// ---------------------------------------------------------------------------
// sidechain_duck_envelope_top
// attack / hold / release ducking gain, one item per audio sample
// ---------------------------------------------------------------------------
// One request item per audio sample carries the onset flag; one response item
// carries the Q1.15 duck gain and a flag for an onset lost to a full pending
// queue. A small sequencer works each item: it retires every pending onset that
// is through its attack, then runs up to two envelope points (the lead envelope
// and the oldest pending onset) through one shared 16x16 multiplier and one
// divider that retires 4 quotient bits per clock. An item ends only once the
// previous response has been taken. The request side is not ready while an
// item is at work. The response sits in an output register, so the next item
// is taken while it waits. Configuration writes are taken at any time and
// belong between items.
// ---------------------------------------------------------------------------
module sidechain_duck_envelope_top #(
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] onset, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [15:0] gain, [16] onset_dropped, [23:17] zero
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [sduck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data
);

   localparam int CNT_W = $clog2(PENDING_DEPTH+1);
   localparam int AW    = sduck_pkg::AGE_W;
   localparam int GW    = sduck_pkg::GAIN_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_CHECK  = 4'd1;
   localparam logic [3:0] S_BUBBLE = 4'd2;
   localparam logic [3:0] S_PUSH   = 4'd3;
   localparam logic [3:0] S_SEL    = 4'd4;
   localparam logic [3:0] S_SEG1   = 4'd5;
   localparam logic [3:0] S_SEG2   = 4'd6;
   localparam logic [3:0] S_MUL    = 4'd7;
   localparam logic [3:0] S_DSTART = 4'd8;
   localparam logic [3:0] S_DWAIT  = 4'd9;
   localparam logic [3:0] S_FIN    = 4'd10;
   localparam logic [3:0] S_OUT    = 4'd11;

   // configuration
   logic [sduck_pkg::ATK_W-1:0] attack_len_ff;
   logic [15:0]                 hold_len_ff;
   logic [15:0]                 release_len_ff;
   logic [GW-1:0]               min_gain_ff;

   // sequencer and envelope state
   logic [3:0]                    state_ff, state_in;
   logic                          onset_ff, onset_in;
   logic                          dropped_ff, dropped_in;
   logic [sduck_pkg::STAMP_W-1:0] sample_clock_ff, sample_clock_in;
   logic [AW-1:0]                 lead_age_ff, lead_age_in;
   logic                          lead_valid_ff, lead_valid_in;
   logic                          lead_todo_ff, lead_todo_in;
   logic                          head_todo_ff, head_todo_in;
   logic [sduck_pkg::STAMP_W-1:0] head_age_ff, head_age_in;
   logic [AW-1:0]                 age_ff, age_in;
   logic [AW-1:0]                 seg_rem_ff, seg_rem_in;
   logic                          is_attack_ff, is_attack_in;
   logic [GW-1:0]                 num_ff, num_in;
   logic [sduck_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [GW-1:0]                 gain_ff, gain_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]                 rsp_gain_ff, rsp_gain_in;
   logic                          rsp_dropped_ff, rsp_dropped_in;

   sduck_pkg::fifo_ctrl_type      fifo_ctrl;
   logic [sduck_pkg::STAMP_W-1:0] head_stamp;
   logic [CNT_W-1:0]              fifo_count;

   logic                          div_start;
   logic [GW-1:0]                 div_divisor;
   logic [GW-1:0]                 div_quot;
   logic                          div_done;

   logic [sduck_pkg::ATK_W-1:0]   atk_eff;
   logic [15:0]                   rel_eff;
   logic [GW-1:0]                 depth_d;
   logic [sduck_pkg::STAMP_W-1:0] head_age_now;
   logic [AW-1:0]                 rel_off;
   logic [GW-1:0]                 env_val;

   sduck_fifo #(
      .DEPTH(PENDING_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (fifo_ctrl),
      .wr_stamp   (sample_clock_ff),
      .head_stamp (head_stamp),
      .count      (fifo_count)
   );

   sduck_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (prod_ff),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .done     (div_done)
   );

   // zero lengths act as one
   assign atk_eff      = (attack_len_ff == '0) ? 12'd1 : attack_len_ff;
   assign rel_eff      = (release_len_ff == '0) ? 16'd1 : release_len_ff;
   assign depth_d      = sduck_pkg::UNITY - min_gain_ff;
   assign head_age_now = sample_clock_ff - head_stamp;
   assign rel_off      = seg_rem_ff - {2'b00, hold_len_ff};
   assign div_divisor  = is_attack_ff ? {4'b0000, atk_eff} : rel_eff;
   assign env_val      = is_attack_ff ? sduck_pkg::UNITY - div_quot : min_gain_ff + div_quot;

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0000000, rsp_dropped_ff, rsp_gain_ff};

   always_comb begin
      state_in        = state_ff;
      onset_in        = onset_ff;
      dropped_in      = dropped_ff;
      sample_clock_in = sample_clock_ff;
      lead_age_in     = lead_age_ff;
      lead_valid_in   = lead_valid_ff;
      lead_todo_in    = lead_todo_ff;
      head_todo_in    = head_todo_ff;
      head_age_in     = head_age_ff;
      age_in          = age_ff;
      seg_rem_in      = seg_rem_ff;
      is_attack_in    = is_attack_ff;
      num_in          = num_ff;
      prod_in         = prod_ff;
      gain_in         = gain_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_tready;
      rsp_gain_in     = rsp_gain_ff;
      rsp_dropped_in  = rsp_dropped_ff;
      fifo_ctrl       = '0;
      div_start       = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               onset_in   = req_tdata[0];
               dropped_in = 1'b0;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            // retire the head once its attack is over; it becomes the lead
            if (fifo_count != '0 && head_age_now >= {4'b0000, atk_eff}) begin
               fifo_ctrl.pop = 1'b1;
               lead_age_in   = {2'b00, head_age_now};
               lead_valid_in = 1'b1;
               state_in      = S_BUBBLE;
            end else begin
               head_age_in  = head_age_now;
               head_todo_in = (fifo_count != '0);
               state_in     = S_PUSH;
            end
         end
         S_BUBBLE: begin
            state_in = S_CHECK;
         end
         S_PUSH: begin
            if (onset_ff) begin
               if (fifo_count < CNT_W'(PENDING_DEPTH)) begin
                  fifo_ctrl.push = 1'b1;
               end else begin
                  dropped_in = 1'b1;
               end
            end
            // oldest pending onset is the deepest one, all of them in attack
            gain_in      = sduck_pkg::UNITY;
            lead_todo_in = lead_valid_ff & ~min_gain_ff[GW-1];
            head_todo_in = head_todo_ff & ~min_gain_ff[GW-1];
            state_in     = S_SEL;
         end
         S_SEL: begin
            if (lead_todo_ff) begin
               lead_todo_in = 1'b0;
               age_in       = lead_age_ff;
               state_in     = S_SEG1;
            end else if (head_todo_ff) begin
               head_todo_in = 1'b0;
               age_in       = {2'b00, head_age_ff};
               state_in     = S_SEG1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SEG1: begin
            if (age_ff < {6'd0, atk_eff}) begin
               is_attack_in = 1'b1;
               num_in       = age_ff[GW-1:0];
               state_in     = S_MUL;
            end else begin
               seg_rem_in = age_ff - {6'd0, atk_eff};
               state_in   = S_SEG2;
            end
         end
         S_SEG2: begin
            if (seg_rem_ff < {2'b00, hold_len_ff}) begin
               if (min_gain_ff < gain_ff) begin
                  gain_in = min_gain_ff;
               end
               state_in = S_SEL;
            end else if (rel_off < {2'b00, rel_eff}) begin
               is_attack_in = 1'b0;
               num_in       = rel_off[GW-1:0];
               state_in     = S_MUL;
            end else begin
               state_in = S_SEL;
            end
         end
         S_MUL: begin
            prod_in  = depth_d * num_ff;
            state_in = S_DSTART;
         end
         S_DSTART: begin
            div_start = 1'b1;
            state_in  = S_DWAIT;
         end
         S_DWAIT: begin
            if (div_done) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (env_val < gain_ff) begin
               gain_in = env_val;
            end
            state_in = S_SEL;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in    = 1'b1;
               rsp_gain_in     = gain_ff;
               rsp_dropped_in  = dropped_ff;
               sample_clock_in = sample_clock_ff + 1'b1;
               if (lead_valid_ff && lead_age_ff != sduck_pkg::AGE_MAX) begin
                  lead_age_in = lead_age_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         sample_clock_ff <= '0;
         lead_age_ff     <= '0;
         lead_valid_ff   <= 1'b0;
         lead_todo_ff    <= 1'b0;
         head_todo_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         sample_clock_ff <= sample_clock_in;
         lead_age_ff     <= lead_age_in;
         lead_valid_ff   <= lead_valid_in;
         lead_todo_ff    <= lead_todo_in;
         head_todo_ff    <= head_todo_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      onset_ff       <= onset_in;
      dropped_ff     <= dropped_in;
      head_age_ff    <= head_age_in;
      age_ff         <= age_in;
      seg_rem_ff     <= seg_rem_in;
      is_attack_ff   <= is_attack_in;
      num_ff         <= num_in;
      prod_ff        <= prod_in;
      gain_ff        <= gain_in;
      rsp_gain_ff    <= rsp_gain_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_len_ff  <= sduck_pkg::ATTACK_LEN_RST;
         hold_len_ff    <= sduck_pkg::HOLD_LEN_RST;
         release_len_ff <= sduck_pkg::RELEASE_LEN_RST;
         min_gain_ff    <= sduck_pkg::MIN_GAIN_RST;
      end else if (csr_valid) begin
         case (csr_index)
            sduck_pkg::REG_ATTACK_LEN:  attack_len_ff  <= csr_data[sduck_pkg::ATK_W-1:0];
            sduck_pkg::REG_HOLD_LEN:    hold_len_ff    <= csr_data;
            sduck_pkg::REG_RELEASE_LEN: release_len_ff <= csr_data;
            sduck_pkg::REG_MIN_GAIN:    min_gain_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

endmodule

FILE: hw/rtl/sduck_fifo.sv
// ---------------------------------------------------------------------------
// sduck_fifo
// pending onset stamps in attack, oldest first, registered head read
// ---------------------------------------------------------------------------
module sduck_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sduck_pkg::fifo_ctrl_type        ctrl,
   input  logic [sduck_pkg::STAMP_W-1:0]   wr_stamp,
   output logic [sduck_pkg::STAMP_W-1:0]   head_stamp,
   output logic [$clog2(DEPTH+1)-1:0]      count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH-1);

   logic [sduck_pkg::STAMP_W-1:0] mem [DEPTH];
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [sduck_pkg::STAMP_W-1:0] head_ff;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (ctrl.pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
         count_in  = count_ff - 1'b1;
      end else if (ctrl.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
         count_in  = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push && !ctrl.pop) begin
         mem[wr_ptr_ff] <= wr_stamp;
      end
      head_ff <= mem[rd_ptr_ff];
   end

   assign head_stamp = head_ff;
   assign count      = count_ff;

endmodule

FILE: hw/rtl/sduck_div.sv
// ---------------------------------------------------------------------------
// sduck_div
// iterative restoring divider, a few quotient bits per clock
// ---------------------------------------------------------------------------
module sduck_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [sduck_pkg::PROD_W-1:0]   dividend,
   input  logic [sduck_pkg::GAIN_W-1:0]   divisor,
   output logic [sduck_pkg::GAIN_W-1:0]   quotient,
   output logic                           done
);

   localparam int W = sduck_pkg::GAIN_W;

   // dividend upper half is below the divisor, so the quotient fits W bits
   logic [W-1:0] rem_ff, rem_in;
   logic [W-1:0] low_ff, low_in;
   logic [W-1:0] quot_ff, quot_in;
   logic [W-1:0] dvs_ff, dvs_in;
   logic [sduck_pkg::DIV_CNT_W-1:0] pass_ff, pass_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;

   always_comb begin
      logic [W:0]   trial;
      logic [W-1:0] r;
      logic [W-1:0] lw;
      logic [sduck_pkg::DIV_BITS-1:0] qb;
      r     = rem_ff;
      lw    = low_ff;
      qb    = '0;
      trial = '0;
      for (int i = 0; i < sduck_pkg::DIV_BITS; i++) begin
         trial = {r, lw[W-1]};
         lw    = {lw[W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            r                            = W'(trial - {1'b0, dvs_ff});
            qb[sduck_pkg::DIV_BITS-1-i]  = 1'b1;
         end else begin
            r = trial[W-1:0];
         end
      end

      rem_in  = rem_ff;
      low_in  = low_ff;
      quot_in = quot_ff;
      dvs_in  = dvs_ff;
      pass_in = pass_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend[2*W-1:W];
         low_in  = dividend[W-1:0];
         dvs_in  = divisor;
         quot_in = '0;
         pass_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in  = r;
         low_in  = lw;
         quot_in = {quot_ff[W-sduck_pkg::DIV_BITS-1:0], qb};
         pass_in = pass_ff + 1'b1;
         if (pass_ff == sduck_pkg::DIV_CNT_W'(sduck_pkg::DIV_PASSES-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         pass_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         pass_ff <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
      dvs_ff  <= dvs_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

FILE: bench/sidechain_duck_checker.sv
// ---------------------------------------------------------------------------
// sidechain_duck_checker
// watches the ducking envelope channels, predicts each gain item and compares
// ---------------------------------------------------------------------------
// Register writes update a local copy of the settings. Every accepted request
// item steps a local envelope model by one sample, and the predicted gain and
// drop flag are queued. Every accepted response item is compared field by
// field with the oldest queued prediction.
// ---------------------------------------------------------------------------
module sidechain_duck_checker #(
   parameter int PENDING_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,    // [0] onset, [7:1] zero
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,    // [15:0] gain, [16] onset_dropped, [23:17] zero
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [sduck_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [15:0] csr_data,
   output int          mismatch_count,
   output int          gains_due
);

   typedef struct packed {
      logic [15:0] gain;
      logic        dropped;
   } duck_result_type;

   logic [11:0] attack_len_q;
   logic [15:0] hold_len_q;
   logic [15:0] release_len_q;
   logic [15:0] floor_gain_q;

   logic [15:0] sample_count;
   logic [15:0] onset_stamp [PENDING_DEPTH];
   int          onset_count;
   logic [17:0] lead_age_q;
   logic        lead_live;

   duck_result_type results_due [$];

   function automatic logic [15:0] envelope_gain(input longint unsigned age);
      longint unsigned atk;
      longint unsigned rel;
      longint unsigned depth;
      longint unsigned a;
      atk   = (attack_len_q == 0) ? 64'd1 : 64'(attack_len_q);
      rel   = (release_len_q == 0) ? 64'd1 : 64'(release_len_q);
      depth = 64'(sduck_pkg::UNITY) - 64'(floor_gain_q);
      a     = age;
      if (a < atk) return 16'(64'(sduck_pkg::UNITY) - depth * a / atk);
      a = a - atk;
      if (a < 64'(hold_len_q)) return floor_gain_q;
      a = a - 64'(hold_len_q);
      if (a < rel) return 16'(64'(floor_gain_q) + depth * a / rel);
      return sduck_pkg::UNITY;
   endfunction

   // advances the envelope state by one sample and gives that sample's item
   function automatic duck_result_type step_sample(input logic onset);
      duck_result_type r;
      logic [15:0]  atk;
      logic [15:0]  age;
      logic [15:0]  g;
      atk       = (attack_len_q == 0) ? 16'd1 : {4'd0, attack_len_q};
      r.gain    = sduck_pkg::UNITY;
      r.dropped = 1'b0;

      // onsets done with their attack leave the queue, the newest one leads
      age = sample_count - onset_stamp[0];
      while (onset_count > 0 && age >= atk) begin
         lead_age_q = {2'b00, age};
         lead_live  = 1'b1;
         for (int k = 0; k < PENDING_DEPTH - 1; k++) onset_stamp[k] = onset_stamp[k+1];
         onset_count--;
         age = sample_count - onset_stamp[0];
      end

      if (onset) begin
         if (onset_count < PENDING_DEPTH) begin
            onset_stamp[onset_count] = sample_count;
            onset_count++;
         end else begin
            r.dropped = 1'b1;
         end
      end

      if (floor_gain_q < sduck_pkg::UNITY) begin
         if (lead_live) begin
            g = envelope_gain(64'(lead_age_q));
            if (g < r.gain) r.gain = g;
         end
         for (int k = 0; k < onset_count; k++) begin
            age = sample_count - onset_stamp[k];
            g   = envelope_gain(64'(age));
            if (g < r.gain) r.gain = g;
         end
      end

      sample_count = sample_count + 16'd1;
      if (lead_live && lead_age_q < sduck_pkg::AGE_MAX) lead_age_q = lead_age_q + 18'd1;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      duck_result_type want;
      if (reset) begin
         attack_len_q   = sduck_pkg::ATTACK_LEN_RST;
         hold_len_q     = sduck_pkg::HOLD_LEN_RST;
         release_len_q  = sduck_pkg::RELEASE_LEN_RST;
         floor_gain_q   = sduck_pkg::MIN_GAIN_RST;
         sample_count   = '0;
         onset_count    = 0;
         lead_age_q     = '0;
         lead_live      = 1'b0;
         mismatch_count = 0;
         for (int k = 0; k < PENDING_DEPTH; k++) onset_stamp[k] = '0;
         results_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               sduck_pkg::REG_ATTACK_LEN:  attack_len_q  = csr_data[11:0];
               sduck_pkg::REG_HOLD_LEN:    hold_len_q    = csr_data;
               sduck_pkg::REG_RELEASE_LEN: release_len_q = csr_data;
               sduck_pkg::REG_MIN_GAIN:    floor_gain_q  = csr_data;
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (results_due.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected gain item, expected none, got gain %0d dropped %0b",
                        $time, rsp_tdata[15:0], rsp_tdata[16]);
            end else begin
               want = results_due.pop_front();
               if (rsp_tdata[15:0] !== want.gain) begin
                  mismatch_count++;
                  $display("%0t: gain mismatch, expected %0d, got %0d",
                           $time, want.gain, rsp_tdata[15:0]);
               end
               if (rsp_tdata[16] !== want.dropped) begin
                  mismatch_count++;
                  $display("%0t: onset_dropped mismatch, expected %0b, got %0b",
                           $time, want.dropped, rsp_tdata[16]);
               end
            end
         end
         if (req_tvalid && req_tready) results_due.push_back(step_sample(req_tdata[0]));
      end
      gains_due = results_due.size();
   end

endmodule

FILE: bench/sidechain_duck_envelope_top_tb.sv
// ---------------------------------------------------------------------------
// sidechain_duck_envelope_top_tb
// stimulus and verdict for the sidechain ducking envelope
// ---------------------------------------------------------------------------
// A short directed run covers a full pending queue, the unity floor, zero
// lengths and the widest lengths; then random phases each load new settings
// while idle and stream onset items at varied densities. Both sides idle in
// random bursts except near the end. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module sidechain_duck_envelope_top_tb;

   localparam int DEPTH         = 8;
   localparam int RANDOM_ITEMS  = 950;
   localparam int QUIET_ITEMS   = 120;
   localparam int SETTLE_CYCLES = 64;
   localparam int CYCLE_LIMIT   = 500000;

   logic                              clock      = 1'b0;
   logic                              reset      = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [23:0]                       rsp_tdata;
   logic                              csr_valid  = 1'b0;
   logic                              csr_ready;
   logic [sduck_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [15:0]                       csr_data   = '0;

   int mismatch_count;
   int gains_due;
   int cycle_count = 0;
   int stall_left  = 0;
   bit quiet       = 1'b0;

   always #5 clock = ~clock;

   sidechain_duck_envelope_top #(.PENDING_DEPTH(DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sidechain_duck_checker #(.PENDING_DEPTH(DEPTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .gains_due      (gains_due)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // response side back-pressure in bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 9) == 0) stall_left <= $urandom_range(1, 19);
      end
   end

   // returns at a falling edge with valid still high
   task automatic send_sample(input bit onset);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, onset};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic put_reg(input logic [sduck_pkg::CSR_INDEX_W-1:0] idx,
                          input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   // settings change only once the block has gone idle
   task automatic load_regs(input logic [11:0] atk, input logic [15:0] hold,
                            input logic [15:0] rel, input logic [15:0] floor_g);
      req_tvalid <= 1'b0;
      while (gains_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      put_reg(sduck_pkg::REG_ATTACK_LEN, {4'd0, atk});
      put_reg(sduck_pkg::REG_HOLD_LEN, hold);
      put_reg(sduck_pkg::REG_RELEASE_LEN, rel);
      put_reg(sduck_pkg::REG_MIN_GAIN, floor_g);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int          total;
      int          per_phase;
      int          odds;
      logic [11:0] atk;
      logic [15:0] hold;
      logic [15:0] rel;
      logic [15:0] floor_g;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: fill the pending queue and overflow it
      send_sample(1'b0);
      repeat (10) send_sample(1'b1);
      // unity floor while the queue is still full
      load_regs(12'd96, 16'd480, 16'd7200, sduck_pkg::UNITY);
      repeat (3) send_sample(1'b1);
      // zero lengths and deepest floor, pending onsets retire at once
      load_regs(12'd0, 16'd0, 16'd0, 16'd0);
      send_sample(1'b1);
      send_sample(1'b0);
      send_sample(1'b1);
      send_sample(1'b0);
      // widest lengths, the lead falls back inside a lengthened attack
      load_regs(12'd4095, 16'd65535, 16'd65535, 16'd0);
      send_sample(1'b1);
      send_sample(1'b0);
      send_sample(1'b1);
      load_regs(12'd1, 16'd0, 16'd65535, 16'd16384);
      send_sample(1'b0);
      send_sample(1'b1);

      total = 0;
      while (total < RANDOM_ITEMS) begin
         case ($urandom_range(0, 7))
            0:       atk = 12'd1;
            1:       atk = 12'd4095;
            2:       atk = 12'd0;
            default: atk = 12'($urandom_range(1, 64));
         endcase
         case ($urandom_range(0, 7))
            0:       hold = 16'd0;
            1:       hold = 16'd65535;
            default: hold = 16'($urandom_range(0, 60));
         endcase
         case ($urandom_range(0, 7))
            0:       rel = 16'd1;
            1:       rel = 16'd65535;
            2:       rel = 16'd0;
            default: rel = 16'($urandom_range(1, 100));
         endcase
         case ($urandom_range(0, 7))
            0:       floor_g = 16'd0;
            1:       floor_g = sduck_pkg::UNITY;
            default: floor_g = 16'($urandom_range(0, 32768));
         endcase
         case ($urandom_range(0, 3))
            0:       odds = 2;
            1:       odds = 6;
            2:       odds = 20;
            default: odds = 80;
         endcase
         load_regs(atk, hold, rel, floor_g);
         quiet     = (total >= RANDOM_ITEMS - QUIET_ITEMS);
         per_phase = $urandom_range(40, 120);
         if (per_phase > RANDOM_ITEMS - total) per_phase = RANDOM_ITEMS - total;
         repeat (per_phase) begin
            send_sample($urandom_range(0, odds - 1) == 0);
            total++;
         end
      end

      req_tvalid <= 1'b0;
      while (gains_due != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/sduck_pkg.sv
hw/rtl/sduck_fifo.sv
hw/rtl/sduck_div.sv
hw/rtl/sidechain_duck_envelope_top.sv
bench/sidechain_duck_checker.sv
bench/sidechain_duck_envelope_top_tb.sv
